@@ rtl/tchr_pkg.sv @@
`timescale 1ns / 1ps
package tchr_pkg;

	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 104;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic KIND_STORE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WRITE  = 6'b000010,
		ST_REREAD = 6'b000100,
		ST_READ   = 6'b001000,
		ST_CMP    = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

endpackage

@@ rtl/tchr_ram.sv @@
`timescale 1ns / 1ps
module tchr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/tick_checksum_history_ring_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  tvalid/tready  tdata                                   tuser        tlast
// s_*       in         accept on both byte, tick, remote checksum (72 bits)   operation    last_byte
// m_*       out        accept on both found, match, checksum, oldest, newest,
//                                     held count (103 bits in 104)            result_kind  none
//
// A snapshot byte that is not the last one leaves the block idle and ready for the next
// byte; the hash update is one 32-bit multiply in the accumulator loop.
// A last byte passes the write and emit states before the next transfer, with a reread
// state between them once the ring is full, because the new oldest tick is read back
// from the tick memory; its result is loaded in the emit state.
// A lookup alternates read and compare states per entry examined, newest first, each step
// waiting on the registered read of the memories. s_tready is high only while no item is in work.
// Reset clears control state only; the memories are not cleared, and entries are read
// only below the fill count. A stalled result holds the block in its emit state.
module tick_checksum_history_ring_core #(
	parameter int unsigned WINDOW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// snapshot_byte [7:0], tick [39:8], remote_checksum [71:40]
	input  logic [tchr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	// operation [0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// found [0], checksum_match [1], checksum [33:2], oldest_tick [65:34],
	// newest_tick [97:66], held_count [102:98], zero [103]
	output logic [tchr_pkg::M_TDATA_W-1:0]  m_tdata,
	// result_kind [0]
	output logic                            m_tuser
);

	import tchr_pkg::*;

	localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW = $clog2(WINDOW + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW);

	state_t          state_q;
	logic [31:0]     acc_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;
	logic            out_kind_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [31:0]     sum_q;
	logic [31:0]     tick_q;
	logic [31:0]     remote_q;
	logic [31:0]     newest_q;
	logic [31:0]     oldest_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   idx_q;
	logic            kind_q;
	logic            found_q;
	logic            match_q;

	logic [7:0]      in_byte;
	logic [31:0]     in_tick;
	logic [31:0]     in_remote;
	logic            s_accept;
	logic [31:0]     acc_mix;
	logic [31:0]     hash_next;
	logic [AW-1:0]   head_next;
	logic [AW-1:0]   head_prev;
	logic [AW-1:0]   ptr_dec;
	logic [AW-1:0]   rd_addr;
	logic            ram_we;
	logic [31:0]     rd_tick;
	logic [31:0]     rd_sum;
	logic            hit;
	logic            scan_end;
	logic            out_free;
	logic            emit_load;
	logic [31:0]     oldest_out;
	logic [31:0]     newest_out;

	assign in_byte   = s_tdata[7:0];
	assign in_tick   = s_tdata[39:8];
	assign in_remote = s_tdata[71:40];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign acc_mix   = acc_q ^ {24'd0, in_byte};
	assign hash_next = acc_mix * FNV_PRIME;

	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	assign head_prev = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign ptr_dec   = (ptr_q == '0) ? LAST_SLOT : ptr_q - AW'(1);

	assign ram_we  = (state_q == ST_WRITE);
	assign rd_addr = (state_q == ST_WRITE) ? head_next : ptr_q;

	tchr_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW)
	) u_tick_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (head_q),
		.wr_data (tick_q),
		.rd_addr (rd_addr),
		.rd_data (rd_tick)
	);

	tchr_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW)
	) u_sum_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (head_q),
		.wr_data (sum_q),
		.rd_addr (rd_addr),
		.rd_data (rd_sum)
	);

	assign hit      = (rd_tick == tick_q);
	assign scan_end = ((CW'(idx_q) + CW'(1)) == count_q);

	assign out_free  = !out_valid_q || m_tready;
	assign emit_load = (state_q == ST_EMIT) && out_free;

	assign oldest_out = (count_q == '0) ? 32'd0 : oldest_q;
	assign newest_out = (count_q == '0) ? 32'd0 : newest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= FNV_BASIS;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (s_tuser == OP_BYTE) begin
							if (s_tlast) begin
								acc_q   <= FNV_BASIS;
								state_q <= ST_WRITE;
							end else begin
								acc_q <= hash_next;
							end
						end else if (count_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_WRITE: begin
					head_q <= head_next;
					if (count_q != FULL_COUNT) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_REREAD;
					end
				end
				ST_REREAD: begin
					state_q <= ST_EMIT;
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit || scan_end) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					tick_q   <= in_tick;
					remote_q <= in_remote;
					kind_q   <= s_tuser;
					found_q  <= (s_tuser == OP_BYTE);
					match_q  <= 1'b0;
					sum_q    <= (s_tuser == OP_BYTE) ? hash_next : 32'd0;
					ptr_q    <= head_prev;
					idx_q    <= '0;
				end
			end
			ST_WRITE: begin
				newest_q <= tick_q;
				if (count_q == '0) begin
					oldest_q <= tick_q;
				end
			end
			ST_REREAD: begin
				oldest_q <= rd_tick;
			end
			ST_CMP: begin
				if (hit) begin
					found_q <= 1'b1;
					sum_q   <= rd_sum;
					match_q <= (rd_sum == remote_q);
				end else begin
					ptr_q <= ptr_dec;
					idx_q <= idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase

		if (emit_load) begin
			out_kind_q <= kind_q;
			out_data_q <= {1'b0, 5'(count_q), newest_out, oldest_out, sum_q, match_q, found_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

endmodule

@@ rtl/tchr_checker.sv @@
`timescale 1ns / 1ps
module tchr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [tchr_pkg::S_TDATA_W-1:0]  s_tdata,
	input logic                            s_tlast,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tchr_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                            m_tuser
);

	import tchr_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast)
			&& $stable(s_tuser))
		else $error("A waiting input transfer changed.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("A stalled result transfer changed.");

	a_store_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STORE) |-> m_tdata[0] && !m_tdata[1])
		else $error("A store result must report found and no match.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_LOOKUP) && !m_tdata[0]
			|-> (m_tdata[33:2] == 32'd0) && !m_tdata[1])
		else $error("A lookup miss must carry a zero checksum and no match.");

	a_match_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0] && (m_tuser == KIND_LOOKUP))
		else $error("A checksum match was reported without a lookup hit.");

endmodule

bind tick_checksum_history_ring_core tchr_checker u_tchr_checker (.*);
